### hw/rtl/cwk_pkg.sv
// ============================================================================
// cwk_pkg
// Shared types, register indexes and the dot length table of the CW keyer.
// ============================================================================
`default_nettype none

package cwk_pkg;

    // configuration register indexes
    localparam logic [2:0] RegSpeedWpm       = 3'd0;
    localparam logic [2:0] RegWeightPercent  = 3'd1;
    localparam logic [2:0] RegKeyerMode      = 3'd2;
    localparam logic [2:0] RegPaddlesSwapped = 3'd3;
    localparam logic [2:0] RegLetterSpaceOn  = 3'd4;

    // keyer modes
    localparam logic [1:0] ModeStraight = 2'd0;
    localparam logic [1:0] ModeIambicA  = 2'd1;
    localparam logic [1:0] ModeIambicB  = 2'd2;

    // register reset values
    localparam logic [6:0] SpeedReset    = 7'd18;
    localparam logic [6:0] WeightReset   = 7'd50;
    localparam logic [1:0] ModeReset     = ModeIambicB;
    localparam logic       SwappedReset  = 1'b1;
    localparam logic       LetterReset   = 1'b0;
    localparam logic [10:0] DotTicksReset  = 11'd66;
    localparam logic [12:0] DashTicksReset = 13'd198;

    // cycles from a register write until the timing pipeline holds fresh values
    localparam int unsigned SettleCycles = 4;
    localparam int unsigned SettleWidth  = $clog2(SettleCycles + 1);

    // dash division by 50: floor(2^25 / 50), result may be one low
    localparam int unsigned RecipShift = 25;
    localparam logic [19:0] Recip50    = 20'd671088;
    localparam logic [12:0] DashMax    = 13'h1FFF;

    typedef struct packed {
        logic [1:0] keyer_mode;
        logic       paddles_swapped;
        logic       letter_space_on;
    } t_mode_cfg;

    typedef struct packed {
        logic [10:0] dot_ticks;
        logic [12:0] dash_ticks;
    } t_timing;

    typedef struct packed {
        logic in_character;
        logic transmit_active;
        logic key_down;
    } t_result;

    // 1200 / speed, speed zero read as one
    localparam logic [10:0] DotLut [128] = '{
        11'd1200, 11'd1200, 11'd600,  11'd400,  11'd300,  11'd240,  11'd200,  11'd171,
        11'd150,  11'd133,  11'd120,  11'd109,  11'd100,  11'd92,   11'd85,   11'd80,
        11'd75,   11'd70,   11'd66,   11'd63,   11'd60,   11'd57,   11'd54,   11'd52,
        11'd50,   11'd48,   11'd46,   11'd44,   11'd42,   11'd41,   11'd40,   11'd38,
        11'd37,   11'd36,   11'd35,   11'd34,   11'd33,   11'd32,   11'd31,   11'd30,
        11'd30,   11'd29,   11'd28,   11'd27,   11'd27,   11'd26,   11'd26,   11'd25,
        11'd25,   11'd24,   11'd24,   11'd23,   11'd23,   11'd22,   11'd22,   11'd21,
        11'd21,   11'd21,   11'd20,   11'd20,   11'd20,   11'd19,   11'd19,   11'd19,
        11'd18,   11'd18,   11'd18,   11'd17,   11'd17,   11'd17,   11'd17,   11'd16,
        11'd16,   11'd16,   11'd16,   11'd16,   11'd15,   11'd15,   11'd15,   11'd15,
        11'd15,   11'd14,   11'd14,   11'd14,   11'd14,   11'd14,   11'd13,   11'd13,
        11'd13,   11'd13,   11'd13,   11'd13,   11'd13,   11'd12,   11'd12,   11'd12,
        11'd12,   11'd12,   11'd12,   11'd12,   11'd12,   11'd11,   11'd11,   11'd11,
        11'd11,   11'd11,   11'd11,   11'd11,   11'd11,   11'd11,   11'd10,   11'd10,
        11'd10,   11'd10,   11'd10,   11'd10,   11'd10,   11'd10,   11'd10,   11'd10,
        11'd10,   11'd9,    11'd9,    11'd9,    11'd9,    11'd9,    11'd9,    11'd9
    };

endpackage

`default_nettype wire

### hw/rtl/cwk_timing.sv
// ============================================================================
// cwk_timing
// Configuration registers and the pipeline that derives dot and dash lengths.
// ============================================================================
`default_nettype none

module cwk_timing (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [6:0]         i_cfg_data,
    output cwk_pkg::t_mode_cfg      o_mode_cfg,
    output cwk_pkg::t_timing        o_timing,
    output logic                    o_busy
);
    import cwk_pkg::*;

    logic [6:0]  r_speed;
    logic [6:0]  r_weight;
    logic [1:0]  r_mode;
    logic        r_swapped;
    logic        r_letter;
    logic [SettleWidth-1:0] r_settle;

    logic [10:0] r_dot_calc;
    logic [8:0]  r_weight3;
    logic [19:0] r_prod;
    logic [19:0] r_prod_d;
    logic [13:0] r_qest;
    logic [12:0] r_dash_calc;

    logic [39:0] prod_recip;
    logic [19:0] rem;
    logic [13:0] quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed   <= SpeedReset;
            r_weight  <= WeightReset;
            r_mode    <= ModeReset;
            r_swapped <= SwappedReset;
            r_letter  <= LetterReset;
            r_settle  <= SettleWidth'(SettleCycles);
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    RegSpeedWpm:       r_speed   <= i_cfg_data;
                    RegWeightPercent:  r_weight  <= i_cfg_data;
                    RegKeyerMode:      r_mode    <= i_cfg_data[1:0];
                    RegPaddlesSwapped: r_swapped <= i_cfg_data[0];
                    RegLetterSpaceOn:  r_letter  <= i_cfg_data[0];
                    default: ;
                endcase
                r_settle <= SettleWidth'(SettleCycles);
            end else if (r_settle != '0) begin
                r_settle <= r_settle - SettleWidth'(1);
            end
        end
    end

    // floor estimate of prod / 50 is exact or one low
    always_comb begin
        prod_recip = 40'(r_prod) * 40'(Recip50);
        rem        = r_prod_d - (20'(r_qest) * 20'd50);
        quot       = (rem >= 20'd50) ? (r_qest + 14'd1) : r_qest;
    end

    always_ff @(posedge i_clk) begin
        r_dot_calc  <= DotLut[r_speed];
        r_weight3   <= {1'b0, r_weight, 1'b0} + {2'b0, r_weight};
        r_prod      <= 20'(r_dot_calc) * 20'(r_weight3);
        r_prod_d    <= r_prod;
        r_qest      <= prod_recip[RecipShift+13:RecipShift];
        r_dash_calc <= (quot > 14'(DashMax)) ? DashMax : quot[12:0];
    end

    assign o_mode_cfg.keyer_mode      = r_mode;
    assign o_mode_cfg.paddles_swapped = r_swapped;
    assign o_mode_cfg.letter_space_on = r_letter;
    assign o_timing.dot_ticks         = r_dot_calc;
    assign o_timing.dash_ticks        = r_dash_calc;
    assign o_busy                     = (r_settle != '0);

endmodule

`default_nettype wire

### hw/rtl/cwk_core.sv
// ============================================================================
// cwk_core
// Keyer phase machine, element timer and paddle memories; one step per tick.
// ============================================================================
`default_nettype none

module cwk_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic               i_left_paddle,
    input  wire logic               i_right_paddle,
    input  cwk_pkg::t_mode_cfg      i_mode_cfg,
    input  cwk_pkg::t_timing        i_timing,
    output cwk_pkg::t_result        o_result
);
    import cwk_pkg::*;

    localparam logic [3:0] PhIdle     = 4'd0;
    localparam logic [3:0] PhDotPrep  = 4'd1;
    localparam logic [3:0] PhDashPrep = 4'd2;
    localparam logic [3:0] PhDotOn    = 4'd3;
    localparam logic [3:0] PhDashOn   = 4'd4;
    localparam logic [3:0] PhDotGap   = 4'd5;
    localparam logic [3:0] PhDashGap  = 4'd6;
    localparam logic [3:0] PhDotNext  = 4'd7;
    localparam logic [3:0] PhDashNext = 4'd8;
    localparam logic [3:0] PhLetter   = 4'd9;

    logic [3:0]  r_phase;
    logic [12:0] r_timer;
    logic        r_dot_pend;
    logic        r_dash_pend;
    logic        r_key;
    logic        r_tx;
    logic [10:0] r_dot_ticks;
    logic [12:0] r_dash_ticks;

    logic [3:0]  n_phase;
    logic [12:0] n_timer;
    logic        n_dot_pend;
    logic        n_dash_pend;
    logic        n_key;
    logic        n_tx;
    logic [10:0] n_dot_ticks;
    logic [12:0] n_dash_ticks;

    logic        dot;
    logic        dash;
    logic        straight;
    logic        mode_a;
    logic        leave;
    logic [12:0] target;
    logic        hit;
    logic [12:0] timer_inc;
    logic        same;
    logic        other;

    always_comb begin
        dot      = i_mode_cfg.paddles_swapped ? i_right_paddle : i_left_paddle;
        dash     = i_mode_cfg.paddles_swapped ? i_left_paddle : i_right_paddle;
        straight = (i_mode_cfg.keyer_mode == ModeStraight);
        mode_a   = (i_mode_cfg.keyer_mode == ModeIambicA);

        // lengths are reloaded on every idle tick
        n_dot_ticks  = (r_phase == PhIdle) ? i_timing.dot_ticks : r_dot_ticks;
        n_dash_ticks = (r_phase == PhIdle) ? i_timing.dash_ticks : r_dash_ticks;

        unique case (r_phase)
            PhDashOn: target = r_dash_ticks;
            PhLetter: target = {1'b0, r_dot_ticks, 1'b0};
            default:  target = {2'b0, r_dot_ticks};
        endcase
        hit       = (r_timer >= target);
        timer_inc = hit ? 13'd0 : (r_timer + 13'd1);

        same  = (r_phase == PhDotNext) ? dot : dash;
        other = (r_phase == PhDotNext) ? dash : dot;

        n_phase     = r_phase;
        n_timer     = r_timer;
        n_dot_pend  = r_dot_pend;
        n_dash_pend = r_dash_pend;
        n_key       = r_key;
        n_tx        = r_tx;
        leave       = 1'b0;

        unique case (r_phase)
            PhIdle: begin
                if (straight && dash) begin
                    if (!n_key) begin
                        n_key = 1'b1;
                        n_tx  = 1'b1;
                    end
                    leave = 1'b1;
                end else if (dot) begin
                    n_phase = PhDotPrep;
                end else if (!straight && dash) begin
                    n_phase = PhDashPrep;
                end else begin
                    if (n_key) begin
                        n_key = 1'b0;
                        n_tx  = 1'b1;
                    end
                    leave = 1'b1;
                end
            end
            PhDotPrep, PhDashPrep: begin
                n_dot_pend  = 1'b0;
                n_dash_pend = 1'b0;
                n_phase     = (r_phase == PhDotPrep) ? PhDotOn : PhDashOn;
            end
            PhDotOn, PhDashOn: begin
                if (!n_key) begin
                    n_key = 1'b1;
                    n_tx  = 1'b1;
                end
                n_timer = timer_inc;
                if (hit) begin
                    n_key   = 1'b0;
                    n_tx    = 1'b1;
                    n_phase = (r_phase == PhDotOn) ? PhDotGap : PhDashGap;
                end
                // mode A forgets the opposite paddle once both are released
                if (mode_a) begin
                    if (r_phase == PhDotOn) begin
                        if (!dot && !dash) n_dash_pend = 1'b0;
                        else if (dash)     n_dash_pend = 1'b1;
                    end else begin
                        if (!dot && !dash) n_dot_pend = 1'b0;
                        else if (dot)      n_dot_pend = 1'b1;
                    end
                end
            end
            PhDotGap: begin
                n_timer = timer_inc;
                if (hit) begin
                    if (!dot && straight) leave = 1'b1;
                    else if (r_dash_pend) n_phase = PhDashPrep;
                    else                  n_phase = PhDotNext;
                end
                if (dash) n_dash_pend = 1'b1;
            end
            PhDashGap: begin
                n_timer = timer_inc;
                if (hit) begin
                    n_phase = r_dot_pend ? PhDotPrep : PhDashNext;
                end
                if (dot) n_dot_pend = 1'b1;
            end
            PhDotNext, PhDashNext: begin
                if (same) begin
                    n_phase = (r_phase == PhDotNext) ? PhDotPrep : PhDashPrep;
                end else if (other) begin
                    n_phase = (r_phase == PhDotNext) ? PhDashPrep : PhDotPrep;
                end else if (i_mode_cfg.letter_space_on) begin
                    n_dot_pend  = 1'b0;
                    n_dash_pend = 1'b0;
                    n_phase     = PhLetter;
                end else begin
                    leave = 1'b1;
                end
            end
            PhLetter: begin
                n_timer = timer_inc;
                if (hit) begin
                    if (r_dot_pend)       n_phase = PhDotPrep;
                    else if (r_dash_pend) n_phase = PhDashPrep;
                    else                  leave = 1'b1;
                end
                if (dot)  n_dot_pend  = 1'b1;
                if (dash) n_dash_pend = 1'b1;
            end
            default: begin
                leave = 1'b1;
            end
        endcase

        if (leave) begin
            n_phase = PhIdle;
            n_tx    = 1'b0;
        end

        o_result.key_down        = n_key;
        o_result.transmit_active = n_tx;
        o_result.in_character    = (n_phase != PhIdle);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PhIdle;
            r_timer      <= 13'd0;
            r_dot_pend   <= 1'b0;
            r_dash_pend  <= 1'b0;
            r_key        <= 1'b0;
            r_tx         <= 1'b0;
            r_dot_ticks  <= DotTicksReset;
            r_dash_ticks <= DashTicksReset;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_timer      <= n_timer;
            r_dot_pend   <= n_dot_pend;
            r_dash_pend  <= n_dash_pend;
            r_key        <= n_key;
            r_tx         <= n_tx;
            r_dot_ticks  <= n_dot_ticks;
            r_dash_ticks <= n_dash_ticks;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/iambic_cw_keyer.sv
// ============================================================================
// iambic_cw_keyer
// Iambic Morse keyer: straight or bug, iambic A and B, one tick per beat.
// ============================================================================
// Each input beat is one keyer tick carrying both paddle levels and produces
// exactly one output beat with the key line, transmit-active and in-character
// flags. Ticks are taken one per clock unless the timing pipeline is settling
// or the result register is stalled; a beat is held in the input register and
// is stepped through the phase machine into the output register. After reset
// and after every configuration write the input is held off while the dot
// table lookup, weight multiply and divide-by-50 pipeline settles. New dot and
// dash lengths are picked up at the next tick that finds the keyer idle; mode,
// paddle swap and letter spacing act at once.
`default_nettype none

module iambic_cw_keyer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input ticks
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [0] left_paddle, [1] right_paddle, [7:2] zero
    // results
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [0] key_down, [1] transmit_active,
                                         // [2] in_character, [7:3] zero
    // configuration writes
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [6:0] i_cfg_data
);
    import cwk_pkg::*;

    t_mode_cfg mode_cfg;
    t_timing   timing;
    t_result   result;
    logic      busy;
    logic      advance;
    logic      step;

    logic      r_in_valid;
    logic      r_in_left;
    logic      r_in_right;
    logic      r_out_valid;
    t_result   r_out;

    cwk_timing u_timing (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mode_cfg  (mode_cfg),
        .o_timing    (timing),
        .o_busy      (busy)
    );

    cwk_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_left_paddle  (r_in_left),
        .i_right_paddle (r_in_right),
        .i_mode_cfg     (mode_cfg),
        .i_timing       (timing),
        .o_result       (result)
    );

    assign advance     = !r_out_valid || i_m_tready;
    assign step        = r_in_valid && advance;
    assign o_s_tready  = !busy && (!r_in_valid || advance);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_left  <= i_s_tdata[0];
            r_in_right <= i_s_tdata[1];
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out.in_character, r_out.transmit_active, r_out.key_down};

endmodule

`default_nettype wire

### hw/rtl/cwk_checker.sv
// ============================================================================
// cwk_checker
// Port-level checks of the CW keyer, bound to the top level.
// ============================================================================
`default_nettype none

module cwk_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_s_tready,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic       i_cfg_valid,
    input wire logic       o_cfg_ready
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat present after reset");

    // timing pipeline must settle before a tick is taken
    a_cfg_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> !o_s_tready)
        else $error("tick accepted right after a configuration write");

    a_reset_holdoff: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("tick accepted right after reset");

    // transmitter switched over only inside a keying sequence
    a_tx_in_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1]) |-> o_m_tdata[2])
        else $error("transmit active while keyer idle");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result beat changed while stalled");

endmodule

bind iambic_cw_keyer cwk_checker u_cwk_checker (.*);

`default_nettype wire

### tb/sv/tb_iambic_cw_keyer.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_iambic_cw_keyer
// Self-checking bench for the iambic keyer: paddle ticks in, keying flags out.
// ============================================================================
// A scoreboard class mirrors the keyer phase machine, the element timer and
// the dot/dash memories and predicts one result per accepted tick. Paddle
// stimulus is mostly held paddle combinations sized to the current element
// length, mixed with short chatter. Settings change only between bursts once
// every result has come back, including a write made mid-character, unused
// mode and register codes, and a saturated dash length at the slowest speed.

module tb_iambic_cw_keyer;

    import cwk_pkg::*;

    // no register behind this index, writes are ignored
    localparam logic [2:0] RegUnused = 3'd7;

    typedef enum logic [3:0] {
        PhIdle     = 4'd0,
        PhDotPrep  = 4'd1,
        PhDashPrep = 4'd2,
        PhDotOn    = 4'd3,
        PhDashOn   = 4'd4,
        PhDotGap   = 4'd5,
        PhDashGap  = 4'd6,
        PhDotNext  = 4'd7,
        PhDashNext = 4'd8,
        PhLetter   = 4'd9
    } t_keyer_phase;

    class t_keying_scoreboard;
        logic [6:0]   speed;
        logic [6:0]   weight;
        logic [1:0]   mode;
        logic         swapped;
        logic         letter_on;
        t_keyer_phase phase;
        int unsigned  elapsed_ticks;
        bit           dot_mem;
        bit           dash_mem;
        bit           key_lvl;
        bit           tx_on;
        int unsigned  dot_len;
        int unsigned  dash_len;
        t_result      expected_q[$];
        int           mismatches;

        function new();
            speed         = SpeedReset;
            weight        = WeightReset;
            mode          = ModeReset;
            swapped       = SwappedReset;
            letter_on     = LetterReset;
            phase         = PhIdle;
            elapsed_ticks = 0;
            dot_mem       = 1'b0;
            dash_mem      = 1'b0;
            key_lvl       = 1'b0;
            tx_on         = 1'b0;
            dot_len       = DotTicksReset;
            dash_len      = DashTicksReset;
            mismatches    = 0;
        endfunction

        function void apply_reg(logic [2:0] index, logic [6:0] value);
            case (index)
                RegSpeedWpm:       speed     = value;
                RegWeightPercent:  weight    = value;
                RegKeyerMode:      mode      = value[1:0];
                RegPaddlesSwapped: swapped   = value[0];
                RegLetterSpaceOn:  letter_on = value[0];
                default: ;
            endcase
        endfunction

        // ticks per element from the written speed, for sizing stimulus
        function int unsigned element_unit();
            return 1200 / ((speed == 0) ? 1 : speed) + 1;
        endfunction

        function bit timer_hit(int unsigned target);
            if (elapsed_ticks >= target) begin
                elapsed_ticks = 0;
                return 1'b1;
            end
            elapsed_ticks = (elapsed_ticks + 1) & 32'h1FFF;
            return 1'b0;
        endfunction

        function void set_key(bit level);
            if (key_lvl != level) begin
                key_lvl = level;
                tx_on   = 1'b1;
            end
        endfunction

        function void note_tick(bit left, bit right);
            bit           dot;
            bit           dash;
            bit           straight;
            bit           mode_a;
            bit           leave;
            bit           same;
            bit           other;
            t_keyer_phase same_ph;
            t_keyer_phase other_ph;
            int unsigned  heavy;
            t_result      res;

            dot      = swapped ? right : left;
            dash     = swapped ? left : right;
            straight = (mode == ModeStraight);
            mode_a   = (mode == ModeIambicA);
            leave    = 1'b0;

            // element lengths follow the registers only between characters
            if (phase == PhIdle) begin
                dot_len  = 1200 / ((speed == 0) ? 1 : speed);
                heavy    = dot_len * 3 * weight / 50;
                dash_len = (heavy > DashMax) ? DashMax : heavy;
            end

            case (phase)
                PhIdle: begin
                    if (straight && dash) begin
                        set_key(1'b1);
                        leave = 1'b1;
                    end else if (dot) begin
                        phase = PhDotPrep;
                    end else if (!straight && dash) begin
                        phase = PhDashPrep;
                    end else begin
                        set_key(1'b0);
                        leave = 1'b1;
                    end
                end
                PhDotPrep: begin
                    dot_mem  = 1'b0;
                    dash_mem = 1'b0;
                    phase    = PhDotOn;
                end
                PhDashPrep: begin
                    dot_mem  = 1'b0;
                    dash_mem = 1'b0;
                    phase    = PhDashOn;
                end
                PhDotOn: begin
                    set_key(1'b1);
                    if (timer_hit(dot_len)) begin
                        set_key(1'b0);
                        phase = PhDotGap;
                    end
                    if (mode_a) begin
                        if (!dot && !dash) dash_mem = 1'b0;
                        else if (dash) dash_mem = 1'b1;
                    end
                end
                PhDashOn: begin
                    set_key(1'b1);
                    if (timer_hit(dash_len)) begin
                        set_key(1'b0);
                        phase = PhDashGap;
                    end
                    if (mode_a) begin
                        if (!dot && !dash) dot_mem = 1'b0;
                        else if (dot) dot_mem = 1'b1;
                    end
                end
                PhDotGap: begin
                    if (timer_hit(dot_len)) begin
                        if (!dot && straight) leave = 1'b1;
                        else if (dash_mem) phase = PhDashPrep;
                        else phase = PhDotNext;
                    end
                    if (dash) dash_mem = 1'b1;
                end
                PhDashGap: begin
                    if (timer_hit(dot_len)) begin
                        if (dot_mem) phase = PhDotPrep;
                        else phase = PhDashNext;
                    end
                    if (dot) dot_mem = 1'b1;
                end
                PhDotNext, PhDashNext: begin
                    same     = (phase == PhDotNext) ? dot : dash;
                    other    = (phase == PhDotNext) ? dash : dot;
                    same_ph  = (phase == PhDotNext) ? PhDotPrep : PhDashPrep;
                    other_ph = (phase == PhDotNext) ? PhDashPrep : PhDotPrep;
                    if (same) begin
                        phase = same_ph;
                    end else if (other) begin
                        phase = other_ph;
                    end else if (letter_on) begin
                        dot_mem  = 1'b0;
                        dash_mem = 1'b0;
                        phase    = PhLetter;
                    end else begin
                        leave = 1'b1;
                    end
                end
                PhLetter: begin
                    if (timer_hit(2 * dot_len)) begin
                        if (dot_mem) phase = PhDotPrep;
                        else if (dash_mem) phase = PhDashPrep;
                        else leave = 1'b1;
                    end
                    if (dot) dot_mem = 1'b1;
                    if (dash) dash_mem = 1'b1;
                end
                default: leave = 1'b1;
            endcase

            if (leave) begin
                phase = PhIdle;
                tx_on = 1'b0;
            end

            res.key_down        = key_lvl;
            res.transmit_active = tx_on;
            res.in_character    = (phase != PhIdle);
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [7:0] beat);
            t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: result beat expected none actual %h", $time, beat);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("key_down", 8'(want.key_down), 8'(beat[0]));
            compare_field("transmit_active", 8'(want.transmit_active), 8'(beat[1]));
            compare_field("in_character", 8'(want.in_character), 8'(beat[2]));
            compare_field("pad bits", 8'h00, 8'(beat[7:3]));
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_s_tvalid  = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata   = 8'h00;
    logic       o_m_tvalid;
    logic       i_m_tready  = 1'b0;
    logic [7:0] o_m_tdata;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index = 3'd0;
    logic [6:0] i_cfg_data  = 7'd0;

    t_keying_scoreboard sb = new();

    bit sender_idle_on = 1'b0;
    bit sink_idle_on   = 1'b1;
    bit long_hold_req  = 1'b0;

    iambic_cw_keyer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic send_tick(input bit left, input bit right);
        int gap;
        if (sender_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, right, left};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_tick(left, right);
    endtask

    // stop offering ticks and wait for every outstanding result
    task automatic end_burst();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [6:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.apply_reg(index, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic release_paddles();
        while (sb.phase != PhIdle) send_tick(1'b0, 1'b0);
    endtask

    // held paddle combinations sized to the element length, plus chatter
    task automatic play_paddles(input int budget);
        int       unit;
        int       run;
        int       left_over;
        bit       chatter;
        bit [1:0] pads;
        unit      = sb.element_unit();
        left_over = budget;
        while (left_over > 0) begin
            chatter = ($urandom_range(0, 4) == 0);
            pads    = 2'($urandom_range(1, 3));
            run     = chatter ? $urandom_range(1, 4) : $urandom_range(1, 4 * unit);
            for (int k = 0; k < run && left_over > 0; k++) begin
                if (chatter) pads = 2'($urandom);
                send_tick(pads[0], pads[1]);
                left_over--;
            end
            if (!chatter) begin
                run = $urandom_range(1, 3 * unit);
                for (int k = 0; k < run && left_over > 0; k++) begin
                    send_tick(1'b0, 1'b0);
                    left_over--;
                end
            end
        end
    endtask

    initial begin : sink_proc
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = 80;
            end else if (hold_left == 0 && sink_idle_on && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(1, 6);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("tb_iambic_cw_keyer: errors");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: idle, dot on the right paddle, dash on the left, squeeze
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        sender_idle_on = 1'b1;
        play_paddles(200);
        release_paddles();
        end_burst();

        // straight mode: dash paddle keys directly, dot paddle sends dots
        sender_idle_on = 1'b0;
        write_reg(RegKeyerMode, 7'(ModeStraight));
        write_reg(RegPaddlesSwapped, 7'd0);
        write_reg(RegSpeedWpm, 7'd127);
        write_reg(RegWeightPercent, 7'd0);
        write_reg(RegLetterSpaceOn, 7'd1);
        write_reg(RegUnused, 7'h7F);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        repeat (14) send_tick(1'b1, 1'b0);
        release_paddles();
        end_burst();

        for (int ph = 0; ph < 12; ph++) begin
            sender_idle_on = (ph < 10) && (ph != 1);
            sink_idle_on   = (ph < 10);
            if (ph == 9) begin
                write_reg(RegSpeedWpm, 7'd127);
                write_reg(RegWeightPercent, 7'd0);
                write_reg(RegKeyerMode, 7'(ModeIambicA));
                write_reg(RegPaddlesSwapped, 7'd1);
                write_reg(RegLetterSpaceOn, 7'd0);
            end else begin
                // mostly fast speeds so characters complete within a burst
                write_reg(RegSpeedWpm, ($urandom_range(0, 6) != 0) ?
                          7'($urandom_range(50, 127)) : 7'($urandom_range(20, 49)));
                write_reg(RegWeightPercent, 7'($urandom_range(0, 127)));
                write_reg(RegKeyerMode, 7'($urandom));
                write_reg(RegPaddlesSwapped, 7'($urandom));
                write_reg(RegLetterSpaceOn, 7'($urandom));
                if ($urandom_range(0, 3) == 0) write_reg(RegUnused, 7'($urandom));
            end
            if (ph == 3) begin
                // sink stalls long while ticks keep coming, block must back up
                sender_idle_on = 1'b0;
                long_hold_req  = 1'b1;
            end
            if (ph == 6) begin
                play_paddles(50);
                end_burst();
                play_paddles(50);
            end else begin
                play_paddles(100);
            end
            end_burst();
        end

        // slowest speed with heaviest weight loads a saturated dash length
        write_reg(RegSpeedWpm, 7'd0);
        write_reg(RegWeightPercent, 7'd127);
        write_reg(RegKeyerMode, 7'(ModeIambicB));
        write_reg(RegPaddlesSwapped, 7'd0);
        write_reg(RegLetterSpaceOn, 7'd0);
        repeat (40) send_tick(1'b0, 1'b1);

        end_burst();
        repeat (8) @(posedge i_clk);
        if (sb.expected_q.size() != 0) begin
            $display("%0t: results expected %0d actual 0", $time, sb.expected_q.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0) begin
            $display("tb_iambic_cw_keyer: clean");
        end else begin
            $display("tb_iambic_cw_keyer: errors");
        end
        $finish;
    end

endmodule
